// ===== rtl/pns_pkg.sv =====
// Shared types and constants for the particle neighbour search block.
`default_nettype none
package pns_pkg;

  localparam int IDX_W   = 6;
  localparam int COORD_W = 32;
  localparam int LEN_W   = 31;
  localparam int SCALE_W = 3;
  localparam int CNT_W   = 7;
  localparam int CFG_W   = 7;
  localparam int REG_W   = 1;

  localparam logic [REG_W-1:0]   REG_RADIUS_SCALE   = 1'b0;
  localparam logic [REG_W-1:0]   REG_PARTICLE_COUNT = 1'b1;
  localparam logic [SCALE_W-1:0] SCALE_RESET        = 3'd3;
  localparam logic [CNT_W-1:0]   COUNT_RESET        = 7'd64;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                      cmd;
    logic [IDX_W-1:0]          particle_index;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [LEN_W-1:0]          smooth_len;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] neighbor_index;
    logic             found;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [LEN_W-1:0]   h;
  } entry_t;

endpackage
`default_nettype wire

// ===== rtl/pns_stream_if.sv =====
// Valid/ready stream interface carrying one beat of payload.
`default_nettype none
interface pns_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/pns_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pns_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wen,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     ren,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/particle_neighbor_search.sv =====
// Top level: particle store and sequenced neighbour search.
`default_nettype none
// A load beat writes one particle into the store; the block stays idle and
// ready for the next beat. A query beat latches its own entry, then for every
// other particle below the effective count reads the entry (ST_NEXT), squares
// dx, dy, dz and the summed smoothing lengths (ST_SX to ST_SH) and compares
// (ST_CMP), skipping its own slot; it ends with the final beat, and the sink can
// stall it by holding ready low. A query of a slot at or beyond the count goes
// straight to its final beat. This sequence comes from the single 33 x 33 bit
// squarer, which is used four times per candidate (dx, dy, dz and the summed
// smoothing lengths), and from the one read port of the particle store, read
// once per candidate. Results leave in ascending index order through an output
// register; the final beat of every query carries last, and a query with no
// neighbours gives one beat with found low. The store holds no reset value:
// querying an unloaded slot is not supported.
module particle_neighbor_search #(
  parameter int MAX_PARTICLES = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wen,
  input  wire logic [pns_pkg::REG_W-1:0]       cfg_index,
  input  wire logic [pns_pkg::CFG_W-1:0]       cfg_data,
  pns_stream_if.sink                           in_ch,
  pns_stream_if.source                         out_ch
);

  localparam int AW    = $clog2(MAX_PARTICLES);
  localparam int ENT_W = $bits(pns_pkg::entry_t);
  localparam int OP_W  = pns_pkg::COORD_W + 1;
  localparam int SQ_W  = 2 * OP_W;
  localparam int ACC_W = SQ_W;
  localparam int HSQ_W = 2 * pns_pkg::COORD_W;
  localparam int SSQ_W = 2 * pns_pkg::SCALE_W;
  localparam int CMP_W = HSQ_W + SSQ_W;

  localparam logic [pns_pkg::CNT_W-1:0] MAX_CNT = pns_pkg::CNT_W'(MAX_PARTICLES);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LATCH, ST_NEXT, ST_SX, ST_SY, ST_SZ, ST_SH, ST_CMP, ST_FINISH
  } state_t;

  function automatic logic [OP_W-1:0] abs_diff(logic [pns_pkg::COORD_W-1:0] a,
                                               logic [pns_pkg::COORD_W-1:0] b);
    logic [OP_W-1:0] d;
    d = {a[pns_pkg::COORD_W-1], a} - {b[pns_pkg::COORD_W-1], b};
    return d[OP_W-1] ? (~d + OP_W'(1)) : d;
  endfunction

  // configuration
  logic [pns_pkg::SCALE_W-1:0] radius_scale;
  logic [pns_pkg::CNT_W-1:0]   particle_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_scale   <= pns_pkg::SCALE_RESET;
      particle_count <= pns_pkg::COUNT_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        pns_pkg::REG_RADIUS_SCALE:   radius_scale <= cfg_data[pns_pkg::SCALE_W-1:0];
        pns_pkg::REG_PARTICLE_COUNT: particle_count <= cfg_data[pns_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  state_t                     state;
  logic [pns_pkg::CNT_W-1:0]  j;
  logic [pns_pkg::CNT_W-1:0]  cnt_q;
  logic [pns_pkg::IDX_W-1:0]  qidx;
  logic [SSQ_W-1:0]           scale_sq;
  pns_pkg::entry_t            ent_i;
  logic [ACC_W-1:0]           acc;
  logic [HSQ_W-1:0]           hsq;
  logic                       pend_valid;
  logic [pns_pkg::IDX_W-1:0]  pend_idx;
  logic                       out_valid;
  pns_pkg::out_item_t         out_data;

  logic                       in_accept;
  logic                       out_free;
  logic                       emit;
  logic [pns_pkg::CNT_W-1:0]  count_eff;
  logic                       idx_in_range;
  logic                       load_ok;

  logic                       ram_wen;
  logic                       ram_ren;
  logic [AW-1:0]              ram_raddr;
  logic [ENT_W-1:0]           ram_rdata;
  pns_pkg::entry_t            ent_j;
  pns_pkg::entry_t            ent_w;

  logic [OP_W-1:0]            sq_op;
  logic [SQ_W-1:0]            sq;
  logic [CMP_W-1:0]           rhs;
  logic [CMP_W-1:0]           lhs;
  logic                       hit;
  logic                       j_is_end;
  logic                       j_is_self;

  assign in_ch.ready  = (state == ST_IDLE);
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid || out_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.payload = out_data;

  assign count_eff    = (particle_count > MAX_CNT) ? MAX_CNT : particle_count;
  assign idx_in_range = {1'b0, in_ch.payload.particle_index} < count_eff;
  assign load_ok      = {1'b0, in_ch.payload.particle_index} < MAX_CNT;

  assign j_is_end  = (j == cnt_q);
  assign j_is_self = (j == {1'b0, qidx});

  // particle store
  assign ent_w.x = in_ch.payload.pos_x;
  assign ent_w.y = in_ch.payload.pos_y;
  assign ent_w.z = in_ch.payload.pos_z;
  assign ent_w.h = in_ch.payload.smooth_len;
  assign ent_j   = pns_pkg::entry_t'(ram_rdata);

  assign ram_wen = in_accept && (in_ch.payload.cmd == pns_pkg::CMD_LOAD) && load_ok;

  always_comb begin
    ram_ren   = 1'b0;
    ram_raddr = j[AW-1:0];
    if (state == ST_IDLE) begin
      ram_raddr = in_ch.payload.particle_index[AW-1:0];
      ram_ren   = in_accept && (in_ch.payload.cmd == pns_pkg::CMD_QUERY);
    end else if (state == ST_NEXT) begin
      ram_ren = !j_is_end && !j_is_self;
    end
  end

  pns_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_PARTICLES)
  ) u_store (
    .clk   (clk),
    .wen   (ram_wen),
    .waddr (in_ch.payload.particle_index[AW-1:0]),
    .wdata (ent_w),
    .ren   (ram_ren),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared squarer
  always_comb begin
    case (state)
      ST_SX:   sq_op = abs_diff(ent_i.x, ent_j.x);
      ST_SY:   sq_op = abs_diff(ent_i.y, ent_j.y);
      ST_SZ:   sq_op = abs_diff(ent_i.z, ent_j.z);
      ST_SH:   sq_op = OP_W'(pns_pkg::COORD_W'(ent_i.h) + pns_pkg::COORD_W'(ent_j.h));
      default: sq_op = '0;
    endcase
  end

  assign sq  = sq_op * sq_op;
  assign rhs = hsq * scale_sq;
  assign lhs = CMP_W'({acc, 2'b00});
  assign hit = lhs < rhs;

  // a beat is loaded into the output register
  assign emit = out_free && (((state == ST_CMP) && hit && pend_valid) ||
                             (state == ST_FINISH));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      j          <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept && (in_ch.payload.cmd == pns_pkg::CMD_QUERY)) begin
            qidx     <= in_ch.payload.particle_index;
            cnt_q    <= count_eff;
            scale_sq <= {3'b000, radius_scale} * {3'b000, radius_scale};
            j        <= '0;
            state    <= idx_in_range ? ST_LATCH : ST_FINISH;
          end
        end
        ST_LATCH: begin
          ent_i <= ent_j;
          state <= ST_NEXT;
        end
        ST_NEXT: begin
          if (j_is_end) begin
            state <= ST_FINISH;
          end else if (j_is_self) begin
            j <= j + pns_pkg::CNT_W'(1);
          end else begin
            state <= ST_SX;
          end
        end
        ST_SX: begin
          acc   <= sq;
          state <= ST_SY;
        end
        ST_SY: begin
          acc   <= acc + sq;
          state <= ST_SZ;
        end
        ST_SZ: begin
          acc   <= acc + sq;
          state <= ST_SH;
        end
        ST_SH: begin
          hsq   <= sq[HSQ_W-1:0];
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (!hit) begin
            j     <= j + pns_pkg::CNT_W'(1);
            state <= ST_NEXT;
          end else if (!pend_valid) begin
            pend_idx   <= j[pns_pkg::IDX_W-1:0];
            pend_valid <= 1'b1;
            j          <= j + pns_pkg::CNT_W'(1);
            state      <= ST_NEXT;
          end else if (out_free) begin
            out_data.neighbor_index <= pend_idx;
            out_data.found          <= 1'b1;
            out_data.last           <= 1'b0;
            pend_idx                <= j[pns_pkg::IDX_W-1:0];
            j                       <= j + pns_pkg::CNT_W'(1);
            state                   <= ST_NEXT;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_data.neighbor_index <= pend_valid ? pend_idx : '0;
            out_data.found          <= pend_valid;
            out_data.last           <= 1'b1;
            pend_valid              <= 1'b0;
            state                   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pend_only_busy: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state != ST_IDLE))
    else $error("pending neighbour held while idle");

  a_finish_emits_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && out_free) |=> (out_valid && out_data.last))
    else $error("query ended without a last beat");

  a_none_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.found) |-> out_data.last)
    else $error("empty result not flagged last");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_NEXT || state == ST_CMP) |-> (j <= cnt_q))
    else $error("scan index past particle count");
`endif

endmodule
`default_nettype wire
